@@ design/nctl_pkg.sv @@
// shared constants and types for the nearest centroid triangle locator
package nctl_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_TRIANGLES = 1024;
    localparam int IDX_BITS      = $clog2(MAX_TRIANGLES);
    localparam int CNT_BITS      = IDX_BITS + 1;
    localparam int ENTRY_BITS    = 9 * COORD_BITS;
    localparam int SUM_BITS      = COORD_BITS + 2;
    localparam int D_BITS        = COORD_BITS + 3;
    localparam int SQ_BITS       = 2 * D_BITS;
    localparam int DSQ_BITS      = SQ_BITS + 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef logic [DSQ_BITS-1:0]          dsq_t;

    typedef struct packed {
        logic clr;
        logic vld;
        logic ok;
        idx_t idx;
    } trk_ctl_t;

endpackage

@@ design/nctl_ram.sv @@
// generic single write port ram with registered read
module nctl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/nctl_axis.sv @@
// per-axis cell: bounding box or centroid sign check, then squared offset
module nctl_axis (
    input  logic                                 clk,
    input  logic                                 chk_sum,
    input  nctl_pkg::coord_t                     a,
    input  nctl_pkg::coord_t                     b,
    input  nctl_pkg::coord_t                     c,
    input  nctl_pkg::coord_t                     p,
    output logic                                 ok,
    output nctl_pkg::sq_t                        sq
);
    import nctl_pkg::*;

    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] pe;
    logic signed [SUM_BITS-1:0] p3;
    logic                       in_range;
    logic signed [D_BITS-1:0]   d_next;
    logic signed [D_BITS-1:0]   d_reg;
    logic                       ok1_next;
    logic                       ok1_reg;
    logic signed [SQ_BITS-1:0]  d_ext;
    logic signed [SQ_BITS-1:0]  prod;
    sq_t                        sq_reg;
    logic                       ok2_reg;

    assign sum = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
    assign pe  = SUM_BITS'(p);
    assign p3  = pe + (pe <<< 1);
    assign in_range = ((p >= a) || (p >= b) || (p >= c)) &&
                      ((p <= a) || (p <= b) || (p <= c));
    assign d_next   = D_BITS'(p3) - D_BITS'(sum);
    assign ok1_next = chk_sum ? ~sum[SUM_BITS-1] : in_range;

    assign d_ext = {{(SQ_BITS-D_BITS){d_reg[D_BITS-1]}}, d_reg};
    assign prod  = d_ext * d_ext;

    always_ff @(posedge clk) begin
        d_reg   <= d_next;
        ok1_reg <= ok1_next;
        sq_reg  <= sq_t'(prod);
        ok2_reg <= ok1_reg;
    end

    assign ok = ok2_reg;
    assign sq = sq_reg;

endmodule

@@ design/nctl_track.sv @@
// nearest distance tracker: sums squared terms and keeps the best index
module nctl_track (
    input  logic               aclk,
    input  logic               aresetn,
    input  nctl_pkg::trk_ctl_t ctl,
    input  nctl_pkg::sq_t      sq_x,
    input  nctl_pkg::sq_t      sq_y,
    input  nctl_pkg::sq_t      sq_z,
    output logic               busy,
    output logic               found,
    output nctl_pkg::idx_t     found_index
);
    import nctl_pkg::*;

    dsq_t dsq_reg;
    logic vld_reg;
    logic ok_reg;
    idx_t idx_reg;
    dsq_t best_reg;
    logic hit_reg;
    idx_t best_idx_reg;
    logic take;

    assign take = vld_reg && ok_reg && (!hit_reg || (dsq_reg <= best_reg));

    always_ff @(posedge aclk) begin
        dsq_reg <= DSQ_BITS'(sq_x) + DSQ_BITS'(sq_y) + DSQ_BITS'(sq_z);
        ok_reg  <= ctl.ok;
        idx_reg <= ctl.idx;
        if (take) begin
            best_reg <= dsq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= 1'b0;
            hit_reg      <= 1'b0;
            best_idx_reg <= '0;
        end else begin
            vld_reg <= ctl.vld;
            if (ctl.clr) begin
                hit_reg      <= 1'b0;
                best_idx_reg <= '0;
            end else if (take) begin
                hit_reg      <= 1'b1;
                best_idx_reg <= idx_reg;
            end
        end
    end

    assign busy        = vld_reg;
    assign found       = hit_reg;
    assign found_index = best_idx_reg;

endmodule

@@ design/nearest_centroid_triangle_locate.sv @@
// top level: triangle table, scan control, axis cells and nearest tracker
// load beat: written straight into the table ram; s_ready stays high, so load beats can follow back to back
// query beat: scans the first n table entries, n = min(scan count, 1024), then presents the result
// a new beat is taken only once the previous query's result is loaded; a stalled result holds the next one
// scan pipeline: ram read, offset and box check, square, sum, compare
// reset (aresetn low, synchronous) clears control and the scan count; table is not cleared
module nearest_centroid_triangle_locate (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [nctl_pkg::CNT_BITS-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  nctl_pkg::idx_t             s_tri_index,
    input  nctl_pkg::coord_t           s_first_x,
    input  nctl_pkg::coord_t           s_first_y,
    input  nctl_pkg::coord_t           s_first_z,
    input  nctl_pkg::coord_t           s_second_x,
    input  nctl_pkg::coord_t           s_second_y,
    input  nctl_pkg::coord_t           s_second_z,
    input  nctl_pkg::coord_t           s_third_x,
    input  nctl_pkg::coord_t           s_third_y,
    input  nctl_pkg::coord_t           s_third_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output nctl_pkg::idx_t             m_found_index
);
    import nctl_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;
    localparam cnt_t       MAX_CNT  = cnt_t'(MAX_TRIANGLES);

    logic [1:0] state_reg, state_next;
    cnt_t       count_reg;
    cnt_t       n_reg, n_next;
    cnt_t       addr_reg, addr_next;
    coord_t     px_reg, py_reg, pz_reg;
    logic       v1_reg, v2_reg, v3_reg;
    idx_t       idx1_reg, idx2_reg, idx3_reg;
    logic       m_valid_reg;
    logic       m_found_reg;
    idx_t       m_idx_reg;

    logic                  accept;
    logic                  query;
    logic                  scanning;
    logic                  out_load;
    logic [ENTRY_BITS-1:0] wdata;
    logic [ENTRY_BITS-1:0] rdata;
    coord_t                ax, ay, az, bx, by, bz, cx, cy, cz;
    logic                  ok_x, ok_y, ok_z;
    sq_t                   sq_x, sq_y, sq_z;
    trk_ctl_t              trk_ctl;
    logic                  trk_busy;
    logic                  trk_found;
    idx_t                  trk_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign query    = accept && (s_op == OP_QUERY);
    assign scanning = (state_reg == ST_SCAN);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign wdata = {s_third_z, s_third_y, s_third_x,
                    s_second_z, s_second_y, s_second_x,
                    s_first_z, s_first_y, s_first_x};

    nctl_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(MAX_TRIANGLES)
    ) u_store (
        .clk  (aclk),
        .we   (accept && (s_op == OP_LOAD)),
        .waddr(s_tri_index),
        .wdata(wdata),
        .re   (scanning),
        .raddr(addr_reg[IDX_BITS-1:0]),
        .rdata(rdata)
    );

    assign {cz, cy, cx, bz, by, bx, az, ay, ax} = rdata;

    nctl_axis u_axis_x (
        .clk(aclk), .chk_sum(1'b0), .a(ax), .b(bx), .c(cx), .p(px_reg),
        .ok(ok_x), .sq(sq_x)
    );
    nctl_axis u_axis_y (
        .clk(aclk), .chk_sum(1'b0), .a(ay), .b(by), .c(cy), .p(py_reg),
        .ok(ok_y), .sq(sq_y)
    );
    nctl_axis u_axis_z (
        .clk(aclk), .chk_sum(1'b1), .a(az), .b(bz), .c(cz), .p(pz_reg),
        .ok(ok_z), .sq(sq_z)
    );

    assign trk_ctl.clr = query;
    assign trk_ctl.vld = v3_reg;
    assign trk_ctl.ok  = ok_x && ok_y && ok_z;
    assign trk_ctl.idx = idx3_reg;

    nctl_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (trk_ctl),
        .sq_x       (sq_x),
        .sq_y       (sq_y),
        .sq_z       (sq_z),
        .busy       (trk_busy),
        .found      (trk_found),
        .found_index(trk_idx)
    );

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query) begin
                    n_next     = (count_reg > MAX_CNT) ? MAX_CNT : count_reg;
                    addr_next  = '0;
                    state_next = (n_next == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                addr_next = addr_reg + cnt_t'(1);
                if (addr_next == n_reg) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!v1_reg && !v2_reg && !v3_reg && !trk_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (query) begin
            px_reg <= s_first_x;
            py_reg <= s_first_y;
            pz_reg <= s_first_z;
        end
        idx1_reg <= addr_reg[IDX_BITS-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        n_reg    <= n_next;
        addr_reg <= addr_next;
        if (out_load) begin
            m_found_reg <= trk_found;
            m_idx_reg   <= trk_found ? trk_idx : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            v1_reg <= scanning;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_idx_reg;

endmodule

@@ verif/nctl_checker.sv @@
// checker for the triangle locator: mirrors the table, predicts each query result, compares
module nctl_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  nctl_pkg::cnt_t   cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_op,
    input  nctl_pkg::idx_t   s_tri_index,
    input  nctl_pkg::coord_t s_first_x,
    input  nctl_pkg::coord_t s_first_y,
    input  nctl_pkg::coord_t s_first_z,
    input  nctl_pkg::coord_t s_second_x,
    input  nctl_pkg::coord_t s_second_y,
    input  nctl_pkg::coord_t s_second_z,
    input  nctl_pkg::coord_t s_third_x,
    input  nctl_pkg::coord_t s_third_y,
    input  nctl_pkg::coord_t s_third_z,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic             m_found,
    input  nctl_pkg::idx_t   m_found_index,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nctl_pkg::*;

    typedef struct {
        logic found;
        idx_t idx;
    } hit_t;

    localparam longint DIST_CAP = longint'(99999 * 3 * 256) * longint'(99999 * 3 * 256);

    coord_t tri_tab[MAX_TRIANGLES][9];
    int     scan_len;
    hit_t   hits_due[$];

    function automatic hit_t locate(coord_t px, coord_t py, coord_t pz);
        hit_t   res;
        longint pt[3];
        longint best;
        longint dsq;
        longint d;
        longint lo;
        longint hi;
        bit     skip;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        best = DIST_CAP;
        res.found = 1'b0;
        res.idx = '0;
        for (int i = 0; i < scan_len; i++) begin
            if (longint'(tri_tab[i][2]) + tri_tab[i][5] + tri_tab[i][8] < 0) continue;
            skip = 0;
            for (int k = 0; k < 2; k++) begin
                lo = tri_tab[i][k];
                hi = tri_tab[i][k];
                for (int a = 1; a < 3; a++) begin
                    if (tri_tab[i][a*3+k] < lo) lo = tri_tab[i][a*3+k];
                    if (tri_tab[i][a*3+k] > hi) hi = tri_tab[i][a*3+k];
                end
                if (pt[k] < lo || pt[k] > hi) skip = 1;
            end
            if (skip) continue;
            dsq = 0;
            for (int k = 0; k < 3; k++) begin
                d = 3 * pt[k] - (longint'(tri_tab[i][k]) + tri_tab[i][3+k] + tri_tab[i][6+k]);
                dsq += d * d;
            end
            if (dsq <= best) begin
                best = dsq;
                res.found = 1'b1;
                res.idx = idx_t'(i);
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        hit_t want;
        if (!aresetn) begin
            errors = 0;
            scan_len = 0;
            hits_due.delete();
        end else begin
            if (cfg_we) scan_len = (cfg_wdata > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(cfg_wdata);
            if (s_valid && s_ready) begin
                if (s_op == OP_LOAD) begin
                    tri_tab[s_tri_index] = '{s_first_x, s_first_y, s_first_z,
                                             s_second_x, s_second_y, s_second_z,
                                             s_third_x, s_third_y, s_third_z};
                end else begin
                    hits_due.insert(hits_due.size(), locate(s_first_x, s_first_y, s_first_z));
                end
            end
            if (m_valid && m_ready) begin
                if (hits_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat found=%0b index=%0d",
                             $time, m_found, m_found_index);
                end else begin
                    want = hits_due.pop_front();
                    if (m_found !== want.found) begin
                        errors++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, m_found);
                    end
                    if (m_found_index !== want.idx) begin
                        errors++;
                        $display("%0t: found_index expected %0d actual %0d",
                                 $time, want.idx, m_found_index);
                    end
                end
            end
        end
        pending = hits_due.size();
    end

endmodule

@@ verif/testbench.sv @@
// testbench top: drives loads, queries and the scan count, and reports the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nctl_pkg::*;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   cfg_we = 1'b0;
    cnt_t   cfg_wdata = '0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    logic   s_op = OP_LOAD;
    idx_t   s_tri_index = '0;
    coord_t s_first_x = '0, s_first_y = '0, s_first_z = '0;
    coord_t s_second_x = '0, s_second_y = '0, s_second_z = '0;
    coord_t s_third_x = '0, s_third_y = '0, s_third_z = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_found;
    idx_t   m_found_index;
    int     errors;
    int     pending;

    bit     quiet = 0;
    int     stall_left = 0;
    int     scan_len = 0;
    coord_t shadow[MAX_TRIANGLES][9];

    nearest_centroid_triangle_locate uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_tri_index(s_tri_index),
        .s_first_x(s_first_x), .s_first_y(s_first_y), .s_first_z(s_first_z),
        .s_second_x(s_second_x), .s_second_y(s_second_y), .s_second_z(s_second_z),
        .s_third_x(s_third_x), .s_third_y(s_third_y), .s_third_z(s_third_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_found_index(m_found_index)
    );

    nctl_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_tri_index(s_tri_index),
        .s_first_x(s_first_x), .s_first_y(s_first_y), .s_first_z(s_first_z),
        .s_second_x(s_second_x), .s_second_y(s_second_y), .s_second_z(s_second_z),
        .s_third_x(s_third_x), .s_third_y(s_third_y), .s_third_z(s_third_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_found_index(m_found_index), .errors(errors), .pending(pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(50, 10);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task automatic send_beat(logic op, idx_t idx, coord_t c[9]);
        int gap;
        s_op <= op;
        s_tri_index <= idx;
        s_first_x <= c[0];
        s_first_y <= c[1];
        s_first_z <= c[2];
        s_second_x <= c[3];
        s_second_y <= c[4];
        s_second_z <= c[5];
        s_third_x <= c[6];
        s_third_y <= c[7];
        s_third_z <= c[8];
        s_valid <= 1'b1;
        if (op == OP_LOAD) shadow[idx] = c;
        do @(posedge aclk); while (!s_ready);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_count(int value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= cnt_t'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        scan_len = (value > MAX_TRIANGLES) ? MAX_TRIANGLES : value;
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(16'hffff));
    endfunction

    task automatic load_random(idx_t idx);
        coord_t c[9];
        int base[3];
        int spread;
        spread = ($urandom_range(9) == 0) ? 0 : $urandom_range(3000, 1);
        for (int k = 0; k < 3; k++) base[k] = $urandom_range(60000) - 30000;
        if ($urandom_range(4) == 0) base[2] = -base[2];
        for (int a = 0; a < 3; a++)
            for (int k = 0; k < 3; k++)
                c[a*3+k] = ($urandom_range(19) == 0) ? rand_coord()
                         : coord_t'(base[k] + $urandom_range(2 * spread) - spread);
        send_beat(OP_LOAD, idx, c);
    endtask

    task automatic query_random();
        coord_t c[9];
        int i;
        int lo;
        int hi;
        for (int k = 0; k < 9; k++) c[k] = rand_coord();
        if (scan_len > 0 && $urandom_range(9) < 8) begin
            i = $urandom_range(scan_len - 1);
            for (int k = 0; k < 2; k++) begin
                lo = shadow[i][k];
                hi = shadow[i][k];
                for (int a = 1; a < 3; a++) begin
                    if (shadow[i][a*3+k] < lo) lo = shadow[i][a*3+k];
                    if (shadow[i][a*3+k] > hi) hi = shadow[i][a*3+k];
                end
                c[k] = coord_t'(lo + $urandom_range(hi - lo));
            end
            if ($urandom_range(1)) c[2] = shadow[i][2];
        end
        send_beat(OP_QUERY, idx_t'($urandom_range(1023)), c);
    endtask

    initial begin
        int len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table scan
        set_count(0);
        send_beat(OP_QUERY, '0, '{16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0});
        send_beat(OP_QUERY, 10'h3ff, '{16'h7fff, 16'h8000, 16'h7fff,
                  16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        // full-range twins, negative centroid z, small triangle around origin
        send_beat(OP_LOAD, 10'd0, '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'sd0, 16'sd0, 16'h7fff});
        send_beat(OP_LOAD, 10'd1, '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'sd0, 16'sd0, 16'h7fff});
        send_beat(OP_LOAD, 10'd2, '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h8000, 16'sd0, 16'sd0, 16'h8000});
        send_beat(OP_LOAD, 10'd3, '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd1,
                  -16'sd256, -16'sd256, -16'sd1});
        send_beat(OP_LOAD, 10'h3ff, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        set_count(4);
        send_beat(OP_QUERY, '0, '{16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0});
        send_beat(OP_QUERY, '0, '{16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 0});
        send_beat(OP_QUERY, '0, '{16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0});
        send_beat(OP_QUERY, '0, '{16'sd0, 16'sd5, -16'sd5, 0, 0, 0, 0, 0, 0});
        send_beat(OP_QUERY, '0, '{16'sd256, -16'sd256, 16'sd0, 0, 0, 0, 0, 0, 0});
        send_beat(OP_QUERY, '0, '{16'sd257, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0});

        // random phases with small tables
        for (int ph = 0; ph < 7; ph++) begin
            quiet = (ph == 3);
            len = (ph == 0) ? 1 : (ph == 1) ? 64 : $urandom_range(40, 2);
            for (int i = 0; i < len; i++) load_random(idx_t'(i));
            set_count(len);
            for (int n = 0; n < 56; n++) begin
                if ($urandom_range(6) == 0) load_random(idx_t'($urandom_range(1023)));
                else query_random();
            end
        end

        // zero count after a filled table
        quiet = 0;
        set_count(0);
        repeat (2) query_random();

        settle();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
